// ===== design/upd_pkg.sv =====
package upd_pkg;

  // Escape tracking state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam int unsigned MaxOut = 3;

  // One decoded step: up to three output bytes, lowest slot goes out first
  typedef struct packed {
    logic [1:0]              cnt;
    logic                    last;
    logic [MaxOut-1:0][7:0]  data;
  } upd_cmd_t;

  // Uppercase hex digit check: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== design/upd_front.sv =====
module upd_front
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,       // input beat accepted this cycle
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output upd_cmd_t   cmd
);

  upd_phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  logic [4:0] hx;
  logic [4:0] hh;
  logic       f_cnt;
  logic [7:0] f_byte;

  assign hx = hex_digit(in_byte);
  assign hh = hex_digit(held_r);

  // byte decoded from idle
  always_comb begin
    f_cnt  = 1'b1;
    f_byte = in_byte;
    if (in_byte == CH_PCT) begin
      f_cnt = in_last;
    end else if (in_byte == CH_PLUS) begin
      f_byte = CH_SPACE;
    end
  end

  // next state
  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (hx[4] && !in_last) begin
          phase_nxt = PH_DIGIT;
          held_nxt  = in_byte;
        end else if (!hx[4] && in_byte == CH_PCT && !in_last) begin
          phase_nxt = PH_PCT;
        end
      end
      PH_DIGIT: begin
        if (!hx[4] && in_byte == CH_PCT && !in_last) begin
          phase_nxt = PH_PCT;
        end
      end
      default: begin
        if (in_byte == CH_PCT && !in_last) begin
          phase_nxt = PH_PCT;
        end
      end
    endcase
    if (in_last) begin
      held_nxt = 8'd0;
    end
  end

  // step output
  always_comb begin
    cmd      = '0;
    cmd.last = in_last;
    unique case (phase_r)
      PH_PCT: begin
        if (hx[4]) begin
          cmd.cnt     = in_last ? 2'd2 : 2'd0;
          cmd.data[0] = CH_PCT;
          cmd.data[1] = in_byte;
        end else begin
          cmd.cnt     = 2'd1 + {1'b0, f_cnt};
          cmd.data[0] = CH_PCT;
          cmd.data[1] = f_byte;
        end
      end
      PH_DIGIT: begin
        if (hx[4]) begin
          cmd.cnt     = 2'd1;
          cmd.data[0] = {hh[3:0], hx[3:0]};
        end else begin
          cmd.cnt     = 2'd2 + {1'b0, f_cnt};
          cmd.data[0] = CH_PCT;
          cmd.data[1] = held_r;
          cmd.data[2] = f_byte;
        end
      end
      default: begin
        cmd.cnt     = {1'b0, f_cnt};
        cmd.data[0] = f_byte;
      end
    endcase
  end

  assign push = take && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ===== design/upd_queue.sv =====
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  upd_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output upd_cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  upd_cmd_t      ent_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == DepthC);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/upd_back.sv =====
module upd_back
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  upd_cmd_t   head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] sub_r, sub_nxt;
  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       tail;
  logic [7:0] sel;

  // output register free or draining
  assign load = head_valid && (!vld_r || out_ready);
  assign tail = (sub_r == head_cmd.cnt - 2'd1);
  assign pop  = load && tail;

  // pick the byte at the current slot
  always_comb begin
    unique case (sub_r)
      2'd1:    sel = head_cmd.data[1];
      2'd2:    sel = head_cmd.data[2];
      default: sel = head_cmd.data[0];
    endcase
  end

  always_comb begin
    sub_nxt = sub_r;
    if (load) begin
      sub_nxt = tail ? 2'd0 : sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel;
      last_r <= head_cmd.last && tail;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// ===== design/url_percent_decoder.sv =====
// Channel | Dir | Ports                        | Beat
// in      | in  | in_tvalid/tready/tdata/tlast | one encoded byte, tlast ends the string
// out     | out | out_tvalid/tready/tdata/tlast | one decoded byte, tlast on final byte
//
// One input beat per cycle; each beat yields zero to three output bytes.
// The output side drains one byte per cycle while out_tready allows, from a small step queue
// (QDEPTH entries), so an invalid escape emits up to two extra output bytes.
// in_tready drops only when the step queue is full.
// Reset (rst_n low, synchronous) clears the escape state, queue and output.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  logic     take;
  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;
  upd_cmd_t cmd;
  upd_cmd_t head_cmd;

  assign in_tready = !full;
  assign take      = in_tvalid && !full;

  // classify and decode escapes
  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .cmd     (cmd)
  );

  // step queue between the two sides
  upd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // serialize bytes into the output register
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import upd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  // One decoded beat as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  url_percent_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Decoded bytes still owed by the block, oldest first
  dec_beat_t  decoded_q[$];
  upd_phase_t esc_phase = PH_IDLE;
  logic [7:0] esc_digit = 8'h00;

  int unsigned err_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;   // no idling on either side while set
  string       hex_chars = "0123456789ABCDEF";
  string       low_chars = "abcdef";

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------------

  // Uppercase hex value, -1 when the byte is not a digit
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic owe_byte(input logic [7:0] b);
    dec_beat_t e;
    e.data = b;
    e.last = 1'b0;
    decoded_q = {decoded_q, e};
  endtask

  // Byte seen with no escape in progress
  task automatic decode_plain(input logic [7:0] b, input logic last);
    if (b == CH_PCT) begin
      if (last) owe_byte(CH_PCT);
      else esc_phase = PH_PCT;
    end else if (b == CH_PLUS) begin
      owe_byte(CH_SPACE);
    end else begin
      owe_byte(b);
    end
  endtask

  task automatic predict_decode(input logic [7:0] b, input logic last);
    int        v;
    int        h;
    int        n0;
    dec_beat_t e;
    n0 = decoded_q.size();
    v = hex_val(b);
    case (esc_phase)
      PH_PCT: begin
        esc_phase = PH_IDLE;
        if (v >= 0) begin
          if (last) begin
            owe_byte(CH_PCT);
            owe_byte(b);
          end else begin
            esc_digit = b;
            esc_phase = PH_DIGIT;
          end
        end else begin
          owe_byte(CH_PCT);
          decode_plain(b, last);
        end
      end
      PH_DIGIT: begin
        esc_phase = PH_IDLE;
        if (v >= 0) begin
          h = hex_val(esc_digit);
          if (h < 0) h = 0;
          owe_byte(8'(h * 16 + v));
        end else begin
          owe_byte(CH_PCT);
          owe_byte(esc_digit);
          decode_plain(b, last);
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        decode_plain(b, last);
      end
    endcase
    // end of string: flag the final byte, forget any escape
    if (last) begin
      if (decoded_q.size() > n0) begin
        e = decoded_q.pop_back();
        e.last = 1'b1;
        decoded_q = {decoded_q, e};
      end
      esc_phase = PH_IDLE;
      esc_digit = 8'h00;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_decode(b, last);
    beats_sent++;
  endtask

  // Send a byte string, tlast on its final byte
  task automatic send_bytes(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic send_str(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    send_bytes(q);
  endtask

  function automatic logic [7:0] rand_hex();
    return hex_chars[$urandom_range(15)];
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready with random stalls, check every beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    dec_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected out beat data %h last %b", $time, out_tdata, out_tlast);
        err_cnt++;
      end else begin
        e = decoded_q.pop_front();
        if (out_tdata !== e.data) begin
          $display("%0t: out_tdata mismatch: expected %h, actual %h",
                   $time, e.data, out_tdata);
          err_cnt++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: out_tlast mismatch: expected %b, actual %b",
                   $time, e.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $time, decoded_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes and each escape corner
  task automatic test_directed();
    send_str("%41");              // valid escape
    send_str("%ff");              // lowercase breaks right after the percent
    send_str("%4+");              // held digit, then plus decoded afresh
    send_str("%%FF");             // percent breaks and restarts an escape
    send_str("%4%");              // three bytes out on the final beat
    send_str("%");                // lone percent at end of string
    send_str("%A");               // escape cut short by end of string
    send_str("+");
    send_byte(8'h00, 1'b0);       // zero byte is plain data
    send_byte(8'hFF, 1'b1);
    send_str("%7a");              // lowercase breaks after one digit
  endtask

  // Well-formed strings with random content, some cut or broken
  task automatic test_rand_strings(input int unsigned n_beats);
    logic [7:0]  s[$];
    int unsigned stop;
    int unsigned k;
    int unsigned n_tok;
    stop = beats_sent + n_beats;
    while (beats_sent < stop) begin
      s.delete();
      n_tok = $urandom_range(1, 8);
      for (int t = 0; t < n_tok; t++) begin
        k = $urandom_range(99);
        if (k < 45) begin
          s = {s, 8'($urandom_range(255))};
        end else if (k < 55) begin
          s = {s, CH_PLUS};
        end else if (k < 88) begin
          s = {s, CH_PCT};
          s = {s, rand_hex()};
          s = {s, rand_hex()};
        end else if (k < 94) begin
          s = {s, CH_PCT};
          s = {s, rand_hex()};
          s = {s, low_chars[$urandom_range(5)]};
        end else begin
          s = {s, CH_PCT};
          s = {s, ($urandom_range(1) != 0) ? CH_PCT : CH_PLUS};
        end
      end
      // sometimes end the string inside an escape
      if ($urandom_range(4) == 0) begin
        s = {s, CH_PCT};
        if ($urandom_range(1)) s = {s, rand_hex()};
      end
      send_bytes(s);
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate(input int unsigned n_beats);
    calm = 1'b1;
    test_rand_strings(n_beats);
    calm = 1'b0;
  endtask

  // Loose bytes heavy on percent and digits, tlast at random
  task automatic test_noise(input int unsigned n_beats);
    logic [7:0]  b;
    int unsigned k;
    for (int i = 0; i < n_beats; i++) begin
      k = $urandom_range(99);
      if (k < 30) b = CH_PCT;
      else if (k < 60) b = rand_hex();
      else if (k < 75) b = low_chars[$urandom_range(5)];
      else b = 8'($urandom_range(255));
      send_byte(b, (i == n_beats - 1) || ($urandom_range(7) == 0));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_rand_strings(200);
    test_full_rate(60);
    test_noise(45);

    // drop valid on the edge that took the final beat
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== url_percent_decoder.f =====
design/upd_pkg.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder.sv
dv/tb_top.sv
